### rtl/cwu_pkg.sv
`default_nettype none

package cwu_pkg;

    localparam int SEG_W      = 16;
    localparam int THRESH_W   = 32;
    localparam int TMO_CFG_W  = 24;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int OUT_WIN_W  = 32;
    localparam int OUT_TMO_W  = 24;
    localparam int SQ_W       = 2 * SEG_W;
    localparam int DIV_STEPS  = SQ_W;
    localparam int CNT_W      = $clog2(DIV_STEPS);

    localparam logic [SEG_W-1:0]     SEG_RESET    = 16'd1000;
    localparam logic [THRESH_W-1:0]  THRESH_RESET = 32'd64000;
    localparam logic [TMO_CFG_W-1:0] CEIL_RESET   = 24'hFF_FFFF;
    localparam int                   INIT_TMO     = 1000;

    localparam logic OP_TIMEOUT = 1'b0;
    localparam logic OP_ACK     = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SEGMENT_SIZE = 2'd0,
        REG_SSTHRESH     = 2'd1,
        REG_INIT_TIMEOUT = 2'd2,
        REG_CEILING      = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic accept;
        logic square;
        logic div_step;
        logic commit;
    } cwu_cmd_t;

    typedef struct packed {
        logic need_div;
        logic out_free;
    } cwu_status_t;

endpackage

`default_nettype wire

### rtl/cwu_ctrl.sv
`default_nettype none

module cwu_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire cwu_pkg::cwu_status_t status,
    output cwu_pkg::cwu_cmd_t        cmd
);
    import cwu_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SQUARE = 4'b0010,
        ST_DIVIDE = 4'b0100,
        ST_DONE   = 4'b1000
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    state_next = status.need_div ? ST_SQUARE : ST_DONE;
                end
            end
            ST_SQUARE:
            begin
                cmd.square = 1'b1;
                cnt_next   = CNT_W'(DIV_STEPS - 1);
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                cmd.commit = status.out_free;
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

### rtl/cwu_datapath.sv
`default_nettype none

module cwu_datapath #(
    parameter int WINDOW_BITS  = 32,
    parameter int TIMEOUT_BITS = 24
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_write,
    input  wire logic [cwu_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [cwu_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                             operation,
    input  wire logic                             new_data_acked,
    input  wire cwu_pkg::cwu_cmd_t                cmd,
    output cwu_pkg::cwu_status_t                  status,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [cwu_pkg::OUT_WIN_W-1:0]         window,
    output logic [cwu_pkg::OUT_TMO_W-1:0]         timeout_value,
    output logic                                  retransmit,
    output logic                                  restart_timer,
    output logic                                  in_avoidance
);
    import cwu_pkg::*;

    localparam int W      = WINDOW_BITS;
    localparam int T      = TIMEOUT_BITS;
    localparam int CMP_W  = (W > THRESH_W) ? W : THRESH_W;
    localparam int SUM_W  = ((W > SQ_W) ? W : SQ_W) + 1;
    localparam int TC_W   = ((T + 1) > TMO_CFG_W) ? (T + 1) : TMO_CFG_W;
    localparam int OT_W   = (T > OUT_TMO_W) ? T : OUT_TMO_W;
    localparam logic [W-1:0] WIN_MAX   = '1;
    localparam logic [T-1:0] TMO_MAX   = '1;
    localparam logic [T-1:0] TMO_RESET = (T >= 10) ? T'(INIT_TMO) : '1;

    logic [SEG_W-1:0]      seg_reg;
    logic [THRESH_W-1:0]   thresh_reg;
    logic [TMO_CFG_W-1:0]  ceil_reg;
    logic [W-1:0]          win_reg;
    logic [W-1:0]          win_next;
    logic [T-1:0]          tmo_reg;
    logic [T-1:0]          tmo_next;
    logic                  op_reg;
    logic                  fresh_reg;
    logic [SQ_W-1:0]       dvd_reg;
    logic [SQ_W-1:0]       dvd_next;
    logic [W-1:0]          rem_reg;
    logic [W-1:0]          rem_next;
    logic                  out_valid_reg;
    logic [OUT_WIN_W-1:0]  win_out_reg;
    logic [OUT_WIN_W-1:0]  win_out_next;
    logic [OUT_TMO_W-1:0]  tmo_out_reg;
    logic [OUT_TMO_W-1:0]  tmo_out_next;
    logic                  rexmit_reg;
    logic                  avoid_out_reg;

    logic                  avoid;
    logic [W:0]            rem_sh;
    logic [W:0]            rem_diff;
    logic                  fits;
    logic [SUM_W-1:0]      inc;
    logic [SUM_W-1:0]      sum;
    logic [W-1:0]          win_grow;
    logic [TC_W-1:0]       tmo_dbl;
    logic [TC_W-1:0]       tmo_ceil;
    logic [T-1:0]          tmo_sat;
    logic [CMP_W-1:0]      win_ext;
    logic [OT_W-1:0]       tmo_ext;

    assign avoid = CMP_W'(win_reg) >= CMP_W'(thresh_reg);

    assign status.need_div = (operation == OP_ACK) && new_data_acked && avoid
                             && (win_reg != '0);
    assign status.out_free = !out_valid_reg || out_ready;

    // restoring divide, one quotient bit per step; quotient shifts into dvd_reg
    always_comb
    begin
        rem_sh   = {rem_reg, dvd_reg[SQ_W-1]};
        rem_diff = rem_sh - {1'b0, win_reg};
        fits     = rem_sh >= {1'b0, win_reg};
        rem_next = fits ? rem_diff[W-1:0] : rem_sh[W-1:0];
        dvd_next = {dvd_reg[SQ_W-2:0], fits};
    end

    always_comb
    begin
        if (!avoid)
        begin
            inc = SUM_W'(seg_reg);
        end
        else if (win_reg == '0)
        begin
            inc = SUM_W'(WIN_MAX);
        end
        else
        begin
            inc = SUM_W'(dvd_reg);
        end
        sum      = SUM_W'(win_reg) + inc;
        win_grow = (sum > SUM_W'(WIN_MAX)) ? WIN_MAX : sum[W-1:0];

        tmo_dbl  = TC_W'({tmo_reg, 1'b0});
        tmo_ceil = (tmo_dbl > TC_W'(ceil_reg)) ? TC_W'(ceil_reg) : tmo_dbl;
        tmo_sat  = (tmo_ceil > TC_W'(TMO_MAX)) ? TMO_MAX : tmo_ceil[T-1:0];

        if (op_reg == OP_TIMEOUT)
        begin
            win_next = W'(seg_reg);
            tmo_next = tmo_sat;
        end
        else
        begin
            win_next = fresh_reg ? win_grow : win_reg;
            tmo_next = tmo_reg;
        end

        win_ext      = CMP_W'(win_next);
        win_out_next = (win_ext > CMP_W'({OUT_WIN_W{1'b1}})) ? '1
                                                            : win_ext[OUT_WIN_W-1:0];
        tmo_ext      = OT_W'(tmo_next);
        tmo_out_next = (tmo_ext > OT_W'({OUT_TMO_W{1'b1}})) ? '1
                                                           : tmo_ext[OUT_TMO_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg       <= SEG_RESET;
            thresh_reg    <= THRESH_RESET;
            ceil_reg      <= CEIL_RESET;
            win_reg       <= W'(SEG_RESET);
            tmo_reg       <= TMO_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_SEGMENT_SIZE: seg_reg    <= cfg_data[SEG_W-1:0];
                    REG_SSTHRESH:     seg_reg    <= seg_reg;
                    REG_INIT_TIMEOUT: seg_reg    <= seg_reg; // reset value only
                    REG_CEILING:      ceil_reg   <= cfg_data[TMO_CFG_W-1:0];
                    default:          seg_reg    <= seg_reg;
                endcase
                if (cfg_reg_t'(cfg_index) == REG_SSTHRESH)
                begin
                    thresh_reg <= cfg_data[THRESH_W-1:0];
                end
            end
            if (cmd.commit)
            begin
                win_reg       <= win_next;
                tmo_reg       <= tmo_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg    <= operation;
            fresh_reg <= new_data_acked;
        end
        if (cmd.square)
        begin
            dvd_reg <= SQ_W'(seg_reg) * SQ_W'(seg_reg);
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
        if (cmd.commit)
        begin
            win_out_reg   <= win_out_next;
            tmo_out_reg   <= tmo_out_next;
            rexmit_reg    <= (op_reg == OP_TIMEOUT);
            avoid_out_reg <= avoid;
        end
    end

    assign out_valid     = out_valid_reg;
    assign window        = win_out_reg;
    assign timeout_value = tmo_out_reg;
    assign retransmit    = rexmit_reg;
    assign restart_timer = rexmit_reg;
    assign in_avoidance  = avoid_out_reg;

    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || out_ready))
        else $error("result committed over an untaken item");

    a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("committed item not presented");

    a_tmo_ceiling: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && rexmit_reg) |-> (tmo_out_reg <= ceil_reg))
        else $error("doubled timeout above ceiling");

    a_no_step_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !(cmd.div_step || cmd.square || cmd.accept))
        else $error("divider busy while committing");

endmodule

`default_nettype wire

### rtl/tcp_congestion_window_update.sv
// Timeouts, duplicate ACKs, slow-start ACKs and ACKs on a zero window go from accept straight
//   to the result; other congestion-avoidance ACKs first run 1 square + 32 divide steps.
// No new item is taken until the current one is committed; avoidance ACKs also wait on the 32-step serial divider.
// A finished result waits in the output register while the next item is taken.
// Reset (async, active low) loads default registers, window = 1000 bytes,
//   timeout = 1000 (saturated to TIMEOUT_BITS), no result pending.
`default_nettype none

module tcp_congestion_window_update #(
    parameter int WINDOW_BITS  = 32,
    parameter int TIMEOUT_BITS = 24
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_write,
    input  wire logic [cwu_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [cwu_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic                             operation,
    input  wire logic                             new_data_acked,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [cwu_pkg::OUT_WIN_W-1:0]         window,
    output logic [cwu_pkg::OUT_TMO_W-1:0]         timeout_value,
    output logic                                  retransmit,
    output logic                                  restart_timer,
    output logic                                  in_avoidance
);
    import cwu_pkg::*;

    cwu_cmd_t    cmd;
    cwu_status_t status;

    cwu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    cwu_datapath #(
        .WINDOW_BITS  (WINDOW_BITS),
        .TIMEOUT_BITS (TIMEOUT_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .operation      (operation),
        .new_data_acked (new_data_acked),
        .cmd            (cmd),
        .status         (status),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .window         (window),
        .timeout_value  (timeout_value),
        .retransmit     (retransmit),
        .restart_timer  (restart_timer),
        .in_avoidance   (in_avoidance)
    );

endmodule

`default_nettype wire

### verif/testbench.sv
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import cwu_pkg::*;

    localparam int WINDOW_BITS  = 32;
    localparam int TIMEOUT_BITS = 24;
    localparam logic [63:0] WIN_MAX = (64'd1 << WINDOW_BITS) - 64'd1;
    localparam logic [63:0] TMO_MAX = (64'd1 << TIMEOUT_BITS) - 64'd1;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_PRINTED = 40;

    typedef struct packed {
        logic [OUT_WIN_W-1:0] window;
        logic [OUT_TMO_W-1:0] timeout_value;
        logic                 retransmit;
        logic                 restart_timer;
        logic                 in_avoidance;
    } cwnd_result_t;

    typedef struct packed {
        logic         is_cfg;
        cfg_reg_t     reg_sel;
        logic [31:0]  value;
        logic         op;
        logic         fresh;
        logic         typed;
        cwnd_result_t want;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  operation = 1'b0;
    logic                  new_data_acked = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [OUT_WIN_W-1:0]  window;
    logic [OUT_TMO_W-1:0]  timeout_value;
    logic                  retransmit;
    logic                  restart_timer;
    logic                  in_avoidance;

    // predictor state and register copies
    logic [63:0] cwnd;
    logic [63:0] rto;
    logic [63:0] cfg_seg;
    logic [63:0] cfg_thresh;
    logic [63:0] cfg_init_tmo;
    logic [63:0] cfg_ceiling;

    cwnd_result_t pending_results[$];
    stim_row_t    stim_rows[$];
    int           mismatches = 0;
    int           cycle_count = 0;
    int           rx_mode = 0;
    int           rx_left = 0;

    tcp_congestion_window_update #(
        .WINDOW_BITS  (WINDOW_BITS),
        .TIMEOUT_BITS (TIMEOUT_BITS)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .operation      (operation),
        .new_data_acked (new_data_acked),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .window         (window),
        .timeout_value  (timeout_value),
        .retransmit     (retransmit),
        .restart_timer  (restart_timer),
        .in_avoidance   (in_avoidance)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("ERROR cycle %0d: %s", cycle_count, msg);
    endtask

    // result side: check, then pick the next ready level
    always @(posedge clk)
    begin : result_side
        cwnd_result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("result item with nothing expected");
                else
                begin
                    want = pending_results.pop_front();
                    if (window !== want.window)
                        report_mismatch($sformatf("window got %0d want %0d",
                                                  window, want.window));
                    if (timeout_value !== want.timeout_value)
                        report_mismatch($sformatf("timeout_value got %0d want %0d",
                                                  timeout_value, want.timeout_value));
                    if (retransmit !== want.retransmit)
                        report_mismatch($sformatf("retransmit got %b want %b",
                                                  retransmit, want.retransmit));
                    if (restart_timer !== want.restart_timer)
                        report_mismatch($sformatf("restart_timer got %b want %b",
                                                  restart_timer, want.restart_timer));
                    if (in_avoidance !== want.in_avoidance)
                        report_mismatch($sformatf("in_avoidance got %b want %b",
                                                  in_avoidance, want.in_avoidance));
                end
            end
            if (rx_left == 0)
            begin
                rx_mode <= $urandom_range(0, 2);
                rx_left <= $urandom_range(10, 80);
            end
            else
                rx_left <= rx_left - 1;
            case (rx_mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= $urandom_range(0, 1);
                default: out_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    function automatic cwnd_result_t cwnd_update(input logic op, input logic fresh);
        cwnd_result_t r;
        logic [63:0]  grow;
        logic [63:0]  t;
        r = '0;
        r.in_avoidance = (cwnd >= cfg_thresh);
        if (op == OP_TIMEOUT)
        begin
            t = rto << 1;
            if (t > cfg_ceiling)
                t = cfg_ceiling;
            if (t > TMO_MAX)
                t = TMO_MAX;
            rto = t;
            cwnd = (cfg_seg > WIN_MAX) ? WIN_MAX : cfg_seg;
            r.retransmit = 1'b1;
            r.restart_timer = 1'b1;
        end
        else if (fresh)
        begin
            if (!r.in_avoidance)
                grow = cfg_seg;
            else if (cwnd == 0)
                grow = WIN_MAX;
            else
                grow = (cfg_seg * cfg_seg) / cwnd;
            cwnd = cwnd + grow;
            if (cwnd > WIN_MAX)
                cwnd = WIN_MAX;
        end
        r.window = cwnd[OUT_WIN_W-1:0];
        r.timeout_value = rto[OUT_TMO_W-1:0];
        return r;
    endfunction

    function automatic void add_write(input cfg_reg_t r, input logic [31:0] v);
        stim_row_t row;
        row = '0;
        row.is_cfg = 1'b1;
        row.reg_sel = r;
        row.value = v;
        stim_rows.push_back(row);
    endfunction

    function automatic void add_event(input logic op, input logic fresh);
        stim_row_t row;
        row = '0;
        row.op = op;
        row.fresh = fresh;
        stim_rows.push_back(row);
    endfunction

    function automatic void add_known(input logic op, input logic fresh,
                                      input logic [31:0] w, input logic [23:0] t,
                                      input logic avoid);
        stim_row_t row;
        row = '0;
        row.op = op;
        row.fresh = fresh;
        row.typed = 1'b1;
        row.want.window = w;
        row.want.timeout_value = t;
        row.want.retransmit = (op == OP_TIMEOUT);
        row.want.restart_timer = (op == OP_TIMEOUT);
        row.want.in_avoidance = avoid;
        stim_rows.push_back(row);
    endfunction

    task automatic send_event(input logic op, input logic fresh,
                              input logic typed, input cwnd_result_t want);
        cwnd_result_t predicted;
        in_valid <= 1'b1;
        operation <= op;
        new_data_acked <= fresh;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = cwnd_update(op, fresh);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    task automatic write_reg(input cfg_reg_t r, input logic [31:0] v);
        cfg_write <= 1'b1;
        cfg_index <= r;
        cfg_data <= v;
        @(posedge clk);
        case (r)
            REG_SEGMENT_SIZE: cfg_seg = v[SEG_W-1:0];
            REG_SSTHRESH:     cfg_thresh = v;
            REG_INIT_TIMEOUT: cfg_init_tmo = v[TMO_CFG_W-1:0];
            REG_CEILING:      cfg_ceiling = v[TMO_CFG_W-1:0];
            default:          cfg_seg = cfg_seg;
        endcase
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_rows(input int first, input int last);
        stim_row_t row;
        for (int i = first; i <= last; i++)
        begin
            row = stim_rows[i];
            if (row.is_cfg)
            begin
                wait_idle();
                write_reg(row.reg_sel, row.value);
            end
            else
                send_event(row.op, row.fresh, row.typed, row.want);
        end
    endtask

    initial
    begin : stimulus
        int          closing_start;
        int          burst_left;
        int          gap;
        int          tmo_pct;
        logic [31:0] seg;
        logic [31:0] thresh;
        logic [31:0] init_tmo;
        logic [31:0] ceil;
        logic        op;

        cwnd = SEG_RESET;
        rto = INIT_TMO;
        cfg_seg = SEG_RESET;
        cfg_thresh = THRESH_RESET;
        cfg_init_tmo = INIT_TMO;
        cfg_ceiling = CEIL_RESET;

        // state right after reset, slow start, timeouts with the flag either way
        add_known(OP_ACK, 1'b0, 32'd1000, 24'd1000, 1'b0);
        add_known(OP_ACK, 1'b1, 32'd2000, 24'd1000, 1'b0);
        add_known(OP_TIMEOUT, 1'b1, 32'd1000, 24'd2000, 1'b0);
        add_known(OP_TIMEOUT, 1'b0, 32'd1000, 24'd4000, 1'b0);
        add_write(REG_SSTHRESH, 32'd1500);
        add_known(OP_ACK, 1'b1, 32'd2000, 24'd4000, 1'b0);
        add_known(OP_ACK, 1'b1, 32'd2500, 24'd4000, 1'b1);
        add_event(OP_ACK, 1'b1);
        add_event(OP_ACK, 1'b0);
        // timeout above the ceiling drops to it
        add_write(REG_CEILING, 32'd3000);
        add_known(OP_TIMEOUT, 1'b0, 32'd1000, 24'd3000, 1'b1);
        add_write(REG_SEGMENT_SIZE, 32'd65535);
        add_write(REG_INIT_TIMEOUT, 32'hFF_FFFF);
        add_write(REG_SSTHRESH, 32'hFFFF_FFFF);
        add_write(REG_CEILING, 32'hFF_FFFF);
        add_event(OP_ACK, 1'b1);
        add_event(OP_TIMEOUT, 1'b1);
        add_event(OP_ACK, 1'b1);
        add_event(OP_ACK, 1'b1);
        add_write(REG_SEGMENT_SIZE, 32'd1);
        add_write(REG_SSTHRESH, 32'd1);
        add_event(OP_ACK, 1'b1);
        add_event(OP_TIMEOUT, 1'b0);
        add_event(OP_ACK, 1'b1);
        add_event(OP_ACK, 1'b0);

        // zero window and zero timeout, run last since a zero timeout sticks
        closing_start = stim_rows.size();
        add_write(REG_SEGMENT_SIZE, 32'd0);
        add_write(REG_SSTHRESH, 32'd0);
        add_write(REG_CEILING, 32'd0);
        add_known(OP_TIMEOUT, 1'b1, 32'd0, 24'd0, 1'b1);
        add_known(OP_ACK, 1'b1, 32'hFFFF_FFFF, 24'd0, 1'b1);
        add_event(OP_ACK, 1'b1);
        add_write(REG_CEILING, 32'hFF_FFFF);
        add_write(REG_SEGMENT_SIZE, 32'd1000);
        add_write(REG_SSTHRESH, 32'd64000);
        add_known(OP_TIMEOUT, 1'b0, 32'd1000, 24'd0, 1'b1);
        add_event(OP_ACK, 1'b1);
        add_event(OP_ACK, 1'b0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_rows(0, closing_start - 1);

        burst_left = 0;
        for (int phase = 0; phase < 7; phase++)
        begin
            case (phase)
                0:
                begin
                    seg = 32'd1;
                    thresh = 32'd1;
                    init_tmo = 32'd1;
                    ceil = 32'd1;
                end
                1:
                begin
                    seg = 32'd65535;
                    thresh = 32'hFFFF_FFFF;
                    init_tmo = 32'hFF_FFFF;
                    ceil = 32'hFF_FFFF;
                end
                default:
                begin
                    seg = $urandom_range(0, 1) ? $urandom_range(1, 4000)
                                               : $urandom_range(1, 65535);
                    if ($urandom_range(0, 3) == 0)
                        thresh = $urandom_range(1, 32'hFFFF_FFFF);
                    else
                        thresh = seg * $urandom_range(1, 12);
                    init_tmo = $urandom_range(1, 24'hFF_FFFF);
                    ceil = $urandom_range(0, 1) ? $urandom_range(1000, 24'hFF_FFFF)
                                                : $urandom_range(1, 5000);
                end
            endcase
            tmo_pct = $urandom_range(3, 30);
            wait_idle();
            write_reg(REG_SEGMENT_SIZE, seg);
            write_reg(REG_SSTHRESH, thresh);
            write_reg(REG_INIT_TIMEOUT, init_tmo);
            write_reg(REG_CEILING, ceil);
            for (int n = 0; n < 100; n++)
            begin
                if (burst_left == 0)
                begin
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
                    if (gap != 0)
                    begin
                        in_valid <= 1'b0;
                        repeat (gap) @(posedge clk);
                    end
                    burst_left = $urandom_range(1, 40);
                end
                if ($urandom_range(0, 99) == 0)
                    wait_idle();
                op = ($urandom_range(0, 99) < tmo_pct) ? OP_TIMEOUT : OP_ACK;
                send_event(op, ($urandom_range(0, 3) != 0), 1'b0, '0);
                burst_left--;
            end
        end

        run_rows(closing_start, stim_rows.size() - 1);

        wait_idle();
        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
